### hdl/drlu_pkg.sv
// Shared constants, codes and item types for the dense ReLU layer.
package drlu_pkg;

  // Layer geometry.
  localparam int NUM_INPUTS  = 100;
  localparam int NUM_NEURONS = 4;
  localparam int WCOUNT      = NUM_INPUTS * NUM_NEURONS;

  // Field and datapath widths.
  localparam int WADDR_W  = 9;
  localparam int PADDR_W  = $clog2(NUM_INPUTS);
  localparam int PCNT_W   = $clog2(NUM_INPUTS + 1);
  localparam int NEUR_W   = 2;
  localparam int WGT_W    = 16;
  localparam int ACC_W    = 24;
  localparam int ACT_W    = 20;
  localparam int LR_W     = 16;
  localparam int TGT_W    = 4;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_BIAS = 4;

  // Training arithmetic widths and constants.
  localparam int ERR_W    = ACT_W + 1;
  localparam int PROD_W   = ERR_W + LR_W + 1;
  localparam int FRAC_SH  = 16;
  localparam int DELTA_W  = PROD_W - FRAC_SH;
  localparam int TARGET_ONE = 4096;
  localparam int ROUND_HALF = 32768;
  localparam int ACT_MAX  = 1048575;

  // Opcodes of an input transaction; the queue carries the same codes.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_PIXEL = 2'd1;
  localparam logic [1:0] OP_TRAIN = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS0      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS1      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS2      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS3      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE = 3'd4;
  localparam logic [LR_W-1:0]      LR_RESET       = 16'd3277;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [WADDR_W-1:0]      weight_index;
    logic signed [WGT_W-1:0] weight_value;
    logic                    pixel_bit;
    logic                    last_pixel;
    logic [TGT_W-1:0]        target_bits;
  } in_item_t;

  typedef struct packed {
    logic [NEUR_W-1:0] neuron_number;
    logic [ACT_W-1:0]  activation;
    logic              last_result;
  } out_item_t;

  // Command handed from the front end to the execution unit.
  typedef struct packed {
    logic [1:0]         kind;
    logic [WADDR_W-1:0] waddr;
    logic [WGT_W-1:0]   wval;
    logic               pixel;
    logic               last;
    logic [TGT_W-1:0]   tgt;
  } cmd_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### hdl/drlu_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module drlu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 400,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/drlu_front.sv
// Front end: accepts input transactions, drops no-op ones, and queues commands.
module drlu_front (
  input  logic                in_valid,
  output logic                in_stall,
  input  drlu_pkg::in_item_t  in_data,
  input  drlu_pkg::q_status_t q_status,
  output logic                push,
  output drlu_pkg::cmd_t      push_cmd
);
  import drlu_pkg::*;

  logic keep;

  // Loads beyond the weight store and the unused opcode produce no work.
  always_comb begin
    unique case (in_data.opcode)
      OP_LOAD:  keep = (in_data.weight_index < WADDR_W'(WCOUNT));
      OP_PIXEL: keep = 1'b1;
      OP_TRAIN: keep = 1'b1;
      default:  keep = 1'b0;
    endcase
  end

  // A transaction waits only while the queue is full.
  assign in_stall = q_status.full;
  assign push     = in_valid && keep && !q_status.full;

  assign push_cmd.kind  = in_data.opcode;
  assign push_cmd.waddr = in_data.weight_index;
  assign push_cmd.wval  = in_data.weight_value;
  assign push_cmd.pixel = in_data.pixel_bit;
  assign push_cmd.last  = in_data.last_pixel;
  assign push_cmd.tgt   = in_data.target_bits;

endmodule

### hdl/drlu_fifo.sv
// Two-entry command queue between the front end and the execution unit.
module drlu_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  drlu_pkg::cmd_t      push_cmd,
  input  logic                pop,
  output drlu_pkg::cmd_t      pop_cmd,
  output drlu_pkg::q_status_t q_status
);
  import drlu_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign q_status.full  = (cnt_r == 2'd2);
  assign q_status.empty = (cnt_r == 2'd0);
  assign do_push = push && !q_status.full;
  assign do_pop  = pop && !q_status.empty;
  assign pop_cmd = slot_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Payload slots need no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### hdl/drlu_back.sv
// Execution unit: weight and pixel stores, accumulation, output and training sweep.
module drlu_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  drlu_pkg::q_status_t          q_status,
  input  drlu_pkg::cmd_t               pop_cmd,
  output logic                         pop,
  input  logic                         cfg_we,
  input  logic [drlu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [drlu_pkg::WGT_W-1:0]   cfg_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output drlu_pkg::out_item_t          out_data
);
  import drlu_pkg::*;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_ACC     = 3'd1;
  localparam logic [2:0] ST_ACC_END = 3'd2;
  localparam logic [2:0] ST_EMIT    = 3'd3;
  localparam logic [2:0] ST_TR_MUL  = 3'd4;
  localparam logic [2:0] ST_TR_DLT  = 3'd5;
  localparam logic [2:0] ST_TR_RUN  = 3'd6;
  localparam logic [2:0] ST_TR_END  = 3'd7;

  logic [2:0]                st_r;
  logic [PCNT_W-1:0]         pc_r;
  logic [NEUR_W-1:0]         cnt_r;
  logic [PADDR_W-1:0]        j_r;
  logic [WADDR_W-1:0]        addr_r;
  logic                      last_r;
  logic [TGT_W-1:0]          tgt_r;
  logic signed [ACC_W-1:0]   acc_r [NUM_NEURONS];
  logic [ACT_W-1:0]          act_r [NUM_NEURONS];
  logic signed [WGT_W-1:0]   bias_r [NUM_BIAS];
  logic [LR_W-1:0]           lr_r;
  logic                      rd_vld_r;
  logic [NEUR_W-1:0]         rd_n_r;
  logic                      wb_vld_r;
  logic [WADDR_W-1:0]        wb_addr_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [DELTA_W-1:0] delta_r;
  logic                      out_valid_r;
  out_item_t                 out_item_r;

  logic                      w_we;
  logic [WADDR_W-1:0]        w_waddr;
  logic [WGT_W-1:0]          w_wdata;
  logic [WGT_W-1:0]          w_rdata;
  logic                      p_we;
  logic                      p_rdata;
  logic                      pc_room;
  logic                      out_free;
  logic                      emit_fire;
  logic                      last_neuron;

  logic signed [ACC_W:0]     acc_sum;
  logic signed [ACC_W-1:0]   acc_sat;
  logic signed [ACC_W:0]     emit_sum;
  logic [ACT_W-1:0]          emit_act;
  logic [ERR_W-1:0]          tr_err;
  logic signed [PROD_W-1:0]  tr_prod;
  logic signed [PROD_W-1:0]  dlt_sum;
  logic signed [DELTA_W:0]   wb_diff;
  logic [WGT_W-1:0]          wb_sat;

  // Weight store: neuron-major, one row of NUM_INPUTS words per neuron.
  drlu_ram #(.WIDTH(WGT_W), .DEPTH(WCOUNT)) u_wram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (addr_r),
    .rdata (w_rdata)
  );

  // Pixel store: the image pixels kept for the training sweep.
  drlu_ram #(.WIDTH(1), .DEPTH(NUM_INPUTS)) u_pram (
    .clk   (clk),
    .we    (p_we),
    .waddr (pc_r[PADDR_W-1:0]),
    .wdata (pop_cmd.pixel),
    .raddr (j_r),
    .rdata (p_rdata)
  );

  assign pop         = (st_r == ST_IDLE) && !q_status.empty;
  assign pc_room     = (pc_r < PCNT_W'(NUM_INPUTS));
  assign out_free    = !out_valid_r || !out_stall;
  assign emit_fire   = (st_r == ST_EMIT) && out_free;
  assign last_neuron = (cnt_r == NEUR_W'(NUM_NEURONS - 1));
  assign out_valid   = out_valid_r;
  assign out_data    = out_item_r;

  // Store write ports: loads from the queue, training write-back otherwise.
  assign p_we    = pop && (pop_cmd.kind == OP_PIXEL) && pc_room;
  assign w_we    = (pop && (pop_cmd.kind == OP_LOAD)) || (wb_vld_r && p_rdata);
  assign w_waddr = wb_vld_r ? wb_addr_r : pop_cmd.waddr;
  assign w_wdata = wb_vld_r ? wb_sat : pop_cmd.wval;

  // Saturating accumulation of the weight that was read last cycle.
  always_comb begin
    acc_sum = {acc_r[rd_n_r][ACC_W-1], acc_r[rd_n_r]}
            + {{(ACC_W + 1 - WGT_W){w_rdata[WGT_W-1]}}, w_rdata};
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[ACC_W-1:0];
    end
  end

  // Bias add and ReLU with saturation to the activation range.
  always_comb begin
    emit_sum = {acc_r[cnt_r][ACC_W-1], acc_r[cnt_r]}
             + {{(ACC_W + 1 - WGT_W){bias_r[cnt_r][WGT_W-1]}}, bias_r[cnt_r]};
    if (emit_sum[ACC_W]) begin
      emit_act = '0;
    end else if (emit_sum[ACC_W-1:ACT_W] != '0) begin
      emit_act = ACT_W'(ACT_MAX);
    end else begin
      emit_act = emit_sum[ACT_W-1:0];
    end
  end

  // Error term and its product with the learning rate.
  always_comb begin
    tr_err  = {1'b0, act_r[cnt_r]} - (tgt_r[cnt_r] ? ERR_W'(TARGET_ONE) : '0);
    tr_prod = $signed(tr_err) * $signed({1'b0, lr_r});
    dlt_sum = prod_r + PROD_W'(ROUND_HALF);
  end

  // Weight minus delta, saturated to the weight range.
  always_comb begin
    wb_diff = {{(DELTA_W + 1 - WGT_W){w_rdata[WGT_W-1]}}, w_rdata}
            - {delta_r[DELTA_W-1], delta_r};
    if (wb_diff[DELTA_W:WGT_W-1] == '0 || wb_diff[DELTA_W:WGT_W-1] == '1) begin
      wb_sat = wb_diff[WGT_W-1:0];
    end else if (wb_diff[DELTA_W]) begin
      wb_sat = {1'b1, {(WGT_W-1){1'b0}}};
    end else begin
      wb_sat = {1'b0, {(WGT_W-1){1'b1}}};
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BIAS; i++) begin
        bias_r[i] <= '0;
      end
      lr_r <= LR_RESET;
    end else if (cfg_we) begin
      case (cfg_index) inside
        CFG_BIAS0, CFG_BIAS1, CFG_BIAS2, CFG_BIAS3: begin
          bias_r[cfg_index[NEUR_W-1:0]] <= cfg_data;
        end
        CFG_LEARN_RATE: begin
          lr_r <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // Training datapath registers.
  always_ff @(posedge clk) begin
    prod_r    <= tr_prod;
    delta_r   <= dlt_sum[PROD_W-1:FRAC_SH];
    wb_addr_r <= addr_r;
    rd_n_r    <= cnt_r;
  end

  // Sequencer, neuron state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      pc_r        <= '0;
      cnt_r       <= '0;
      j_r         <= '0;
      addr_r      <= '0;
      last_r      <= 1'b0;
      tgt_r       <= '0;
      rd_vld_r    <= 1'b0;
      wb_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_NEURONS; i++) begin
        acc_r[i] <= '0;
        act_r[i] <= '0;
      end
    end else begin
      rd_vld_r <= (st_r == ST_ACC);
      wb_vld_r <= (st_r == ST_TR_RUN);
      // A result stays valid while stalled; a new one is loaded when the register frees.
      out_valid_r <= emit_fire || (out_valid_r && out_stall);
      if (rd_vld_r) begin
        acc_r[rd_n_r] <= acc_sat;
      end

      unique case (st_r)
        ST_IDLE: begin
          if (pop) begin
            last_r <= pop_cmd.last;
            tgt_r  <= pop_cmd.tgt;
            cnt_r  <= '0;
            if (pop_cmd.kind == OP_PIXEL) begin
              if (pc_room) begin
                pc_r <= pc_r + 1'b1;
              end
              if (pc_room && pop_cmd.pixel) begin
                addr_r <= WADDR_W'(pc_r);
                st_r   <= ST_ACC;
              end else if (pop_cmd.last) begin
                st_r <= ST_EMIT;
              end
            end else if (pop_cmd.kind == OP_TRAIN) begin
              addr_r <= '0;
              st_r   <= ST_TR_MUL;
            end
          end
        end
        ST_ACC: begin
          addr_r <= addr_r + WADDR_W'(NUM_INPUTS);
          cnt_r  <= cnt_r + 1'b1;
          if (last_neuron) begin
            st_r <= ST_ACC_END;
          end
        end
        ST_ACC_END: begin
          cnt_r <= '0;
          st_r  <= last_r ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_item_r.neuron_number   <= cnt_r;
            out_item_r.activation      <= emit_act;
            out_item_r.last_result     <= last_neuron;
            act_r[cnt_r]               <= emit_act;
            acc_r[cnt_r]               <= '0;
            cnt_r                      <= cnt_r + 1'b1;
            if (last_neuron) begin
              pc_r <= '0;
              st_r <= ST_IDLE;
            end
          end
        end
        ST_TR_MUL: begin
          st_r <= ST_TR_DLT;
        end
        ST_TR_DLT: begin
          j_r  <= '0;
          st_r <= ST_TR_RUN;
        end
        ST_TR_RUN: begin
          addr_r <= addr_r + 1'b1;
          j_r    <= j_r + 1'b1;
          if (j_r == PADDR_W'(NUM_INPUTS - 1)) begin
            st_r <= ST_TR_END;
          end
        end
        ST_TR_END: begin
          if (last_neuron) begin
            st_r <= ST_IDLE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
            st_r  <= ST_TR_MUL;
          end
        end
        default: begin
          st_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/dense_relu_layer_with_delta_update.sv
// Top level of the dense ReLU layer with delta-rule training.
// One fully connected layer of 4 neurons over 100 binary pixels, with Q3.12
// weights held in a single-port-read weight RAM. A set pixel has the four
// weights of that pixel read one per cycle from the weight RAM's read port. A
// last pixel then adds 4 result transactions, one per cycle when the output is
// not stalled. A train transaction sweeps every weight through the same read
// port. A two-entry command queue separates input acceptance from execution,
// so input can be taken while a result waits. Configuration writes are always
// ready and must be issued only while the layer is idle.
module dense_relu_layer_with_delta_update (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  drlu_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output drlu_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [drlu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [drlu_pkg::WGT_W-1:0]       cfg_data
);
  import drlu_pkg::*;

  q_status_t q_status;
  cmd_t      push_cmd;
  cmd_t      pop_cmd;
  logic      push;
  logic      pop;

  // The register file takes a write in any cycle.
  assign cfg_ready = 1'b1;

  drlu_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_status (q_status),
    .push     (push),
    .push_cmd (push_cmd)
  );

  drlu_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_status (q_status)
  );

  drlu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .pop_cmd   (pop_cmd),
    .pop       (pop),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### sim/drlu_activation_checker.sv
// Watches the layer's channels, predicts every activation and compares it with the result seen.
module drlu_activation_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  drlu_pkg::in_item_t             in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  drlu_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [drlu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [drlu_pkg::WGT_W-1:0]     cfg_data,
  output int                             mismatch_count,
  output int                             pending_count
);
  import drlu_pkg::*;

  localparam longint ACC_TOP    = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint ACC_BOTTOM = -(longint'(1) <<< (ACC_W - 1));
  localparam longint WGT_TOP    = (longint'(1) <<< (WGT_W - 1)) - 1;
  localparam longint WGT_BOTTOM = -(longint'(1) <<< (WGT_W - 1));

  // Shadow copy of the layer's state and registers.
  logic signed [WGT_W-1:0] weight_mem [WCOUNT];
  logic                    pixel_mem  [NUM_INPUTS];
  logic signed [ACC_W-1:0] acc_sum    [NUM_NEURONS];
  logic [ACT_W-1:0]        last_act   [NUM_NEURONS];
  int unsigned             pixel_pos;
  logic signed [WGT_W-1:0] bias_reg   [NUM_BIAS];
  logic [LR_W-1:0]         rate;

  // Activations predicted but not yet seen on the result channel.
  out_item_t expected_acts [$];
  int        fail_tally = 0;

  // Return the shadow state to its reset values.
  task automatic clear_layer();
    for (int n = 0; n < NUM_NEURONS; n++) begin
      acc_sum[n]  = '0;
      last_act[n] = '0;
    end
    for (int b = 0; b < NUM_BIAS; b++) begin
      bias_reg[b] = '0;
    end
    pixel_pos = 0;
    rate = LR_RESET;
    expected_acts.delete();
  endtask

  // Apply one register write.
  task automatic take_reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WGT_W-1:0] val);
    case (idx)
      CFG_BIAS0:      bias_reg[0] = val;
      CFG_BIAS1:      bias_reg[1] = val;
      CFG_BIAS2:      bias_reg[2] = val;
      CFG_BIAS3:      bias_reg[3] = val;
      CFG_LEARN_RATE: rate = val;
      default: ;
    endcase
  endtask

  // Advance the shadow layer by one input transaction and queue the activations it causes.
  task automatic apply_item(input in_item_t it);
    longint    s;
    longint    v;
    longint    err;
    longint    delta;
    longint    w;
    int        k;
    out_item_t want;
    case (it.opcode)
      OP_LOAD: begin
        if (it.weight_index < WCOUNT) weight_mem[it.weight_index] = it.weight_value;
      end
      OP_PIXEL: begin
        // Pixels past the input count are dropped but a last marker still fires.
        if (pixel_pos < NUM_INPUTS) begin
          pixel_mem[pixel_pos] = it.pixel_bit;
          if (it.pixel_bit) begin
            for (int n = 0; n < NUM_NEURONS; n++) begin
              s = longint'(acc_sum[n]) + longint'(weight_mem[n * NUM_INPUTS + pixel_pos]);
              if (s > ACC_TOP) s = ACC_TOP;
              if (s < ACC_BOTTOM) s = ACC_BOTTOM;
              acc_sum[n] = s[ACC_W-1:0];
            end
          end
          pixel_pos++;
        end
        if (it.last_pixel) begin
          for (int n = 0; n < NUM_NEURONS; n++) begin
            v = longint'(acc_sum[n]) + longint'(bias_reg[n]);
            if (v < 0) v = 0;
            if (v > ACT_MAX) v = ACT_MAX;
            last_act[n] = v[ACT_W-1:0];
            want.neuron_number = n[NEUR_W-1:0];
            want.activation    = v[ACT_W-1:0];
            want.last_result   = (n == NUM_NEURONS - 1);
            expected_acts.insert(expected_acts.size(), want);
            acc_sum[n] = '0;
          end
          pixel_pos = 0;
        end
      end
      OP_TRAIN: begin
        // Delta rule on every weight whose pixel is set; the shift floors negative products.
        for (int n = 0; n < NUM_NEURONS; n++) begin
          err = longint'(last_act[n]) - (it.target_bits[n] ? TARGET_ONE : 0);
          delta = (err * longint'(rate) + ROUND_HALF) >>> FRAC_SH;
          for (int j = 0; j < NUM_INPUTS; j++) begin
            if (pixel_mem[j]) begin
              k = n * NUM_INPUTS + j;
              w = longint'(weight_mem[k]) - delta;
              if (w > WGT_TOP) w = WGT_TOP;
              if (w < WGT_BOTTOM) w = WGT_BOTTOM;
              weight_mem[k] = w[WGT_W-1:0];
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // Compare one accepted result with the oldest expectation.
  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_acts.size() == 0) begin
      fail_tally++;
      $display("%0t: unexpected result: neuron %0d activation %0d last %0b",
               $time, got.neuron_number, got.activation, got.last_result);
    end else begin
      want = expected_acts.pop_front();
      if (got.neuron_number != want.neuron_number || got.activation != want.activation ||
          got.last_result != want.last_result) begin
        fail_tally++;
        $display("%0t: result mismatch: expected neuron %0d activation %0d last %0b,",
                 $time, want.neuron_number, want.activation, want.last_result,
                 " actual neuron %0d activation %0d last %0b",
                 got.neuron_number, got.activation, got.last_result);
      end
    end
  endtask

  // Every transaction is taken at the clock edge where its handshake completes.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_layer();
    end else begin
      if (cfg_valid && cfg_ready) take_reg_write(cfg_index, cfg_data);
      if (in_valid && !in_stall) apply_item(in_data);
      if (out_valid && !out_stall) check_result(out_data);
    end
    pending_count  <= expected_acts.size();
    mismatch_count <= fail_tally;
  end

endmodule

### sim/dense_relu_layer_with_delta_update_tb.sv
// Stimulus and verdict for the dense ReLU layer with delta-rule training.
module dense_relu_layer_with_delta_update_tb;
  import drlu_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 1500;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 25;
  localparam int LIVE_PIXELS  = 40;

  localparam logic [1:0]           OP_NONE    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam logic [WGT_W-1:0]     WGT_TOP    = 16'h7FFF;
  localparam logic [WGT_W-1:0]     WGT_BOTTOM = 16'h8000;
  localparam logic [LR_W-1:0]      LR_TOP     = 16'hFFFF;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  in_item_t             in_data   = '0;
  logic                 out_stall = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WGT_W-1:0]     cfg_data  = '0;
  logic                 in_stall;
  logic                 out_valid;
  out_item_t            out_data;
  logic                 cfg_ready;
  int                   mismatch_count;
  int                   pending_count;
  logic                 quiet = 1'b0;
  int                   stall_left = 0;
  int                   img_pos = 0;

  dense_relu_layer_with_delta_update dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  drlu_activation_checker act_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The result side holds off for a random number of cycles after each transaction.
  always @(posedge clk) begin : result_side
    int draw;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      draw = quiet ? 0 : $urandom_range(0, 5);
      stall_left <= draw;
      out_stall  <= (draw != 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end
  end

  // Watchdog on total run length.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("dense_relu_layer_with_delta_update regression: fail");
    $finish;
  end

  // Weight or bias value, with the two extremes drawn often.
  function automatic logic [WGT_W-1:0] pick_weight();
    case ($urandom_range(0, 9))
      0:       return WGT_TOP;
      1:       return WGT_BOTTOM;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [LR_W-1:0] pick_rate();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return LR_TOP;
      2:       return LR_RESET;
      default: return 16'($urandom);
    endcase
  endfunction

  // Every field random, so that fields an opcode ignores still toggle.
  function automatic in_item_t rand_item();
    in_item_t it;
    it.opcode       = 2'($urandom_range(0, 3));
    it.weight_index = 9'($urandom_range(0, 511));
    it.weight_value = 16'($urandom);
    it.pixel_bit    = 1'($urandom_range(0, 1));
    it.last_pixel   = 1'($urandom_range(0, 1));
    it.target_bits  = 4'($urandom_range(0, 15));
    return it;
  endfunction

  function automatic in_item_t load_item(input logic [WADDR_W-1:0] idx,
                                         input logic [WGT_W-1:0] val);
    in_item_t it;
    it = rand_item();
    it.opcode       = OP_LOAD;
    it.weight_index = idx;
    it.weight_value = val;
    return it;
  endfunction

  function automatic in_item_t pixel_item(input logic bit_set, input logic is_last);
    in_item_t it;
    it = rand_item();
    it.opcode     = OP_PIXEL;
    it.pixel_bit  = bit_set;
    it.last_pixel = is_last;
    return it;
  endfunction

  function automatic in_item_t train_item(input logic [TGT_W-1:0] tgt);
    in_item_t it;
    it = rand_item();
    it.opcode      = OP_TRAIN;
    it.target_bits = tgt;
    return it;
  endfunction

  function automatic in_item_t idle_op_item();
    in_item_t it;
    it = rand_item();
    it.opcode = OP_NONE;
    return it;
  endfunction

  // Present one input transaction and hold it until it is taken. Valid stays high on return,
  // so a back-to-back transaction never lowers and raises it in the same step.
  task automatic send_item(input in_item_t it);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // Follow the position the layer gives the next pixel.
    if (it.opcode == OP_PIXEL) begin
      if (it.last_pixel) img_pos = 0;
      else if (img_pos < NUM_INPUTS) img_pos++;
    end
  endtask

  // Feed a run of pixels; density is the percentage of set pixels. Positions from
  // LIVE_PIXELS on stay blank, since the initial loads leave their weights unset.
  task automatic feed_pixels(input int len, input int density, input logic mark_last);
    logic bit_set;
    for (int i = 0; i < len; i++) begin
      bit_set = (img_pos < LIVE_PIXELS) && ($urandom_range(0, 99) < density);
      send_item(pixel_item(bit_set, mark_last && (i == len - 1)));
    end
  endtask

  // Stop sending and wait until every predicted activation has arrived and training is done.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WGT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Write all five registers, optionally preceded by a write to an unused index.
  task automatic program_layer(input logic [WGT_W-1:0] b0, input logic [WGT_W-1:0] b1,
                               input logic [WGT_W-1:0] b2, input logic [WGT_W-1:0] b3,
                               input logic [LR_W-1:0] lr, input logic poke_unused);
    if (poke_unused) cfg_write(CFG_UNUSED, 16'($urandom));
    cfg_write(CFG_BIAS0, b0);
    cfg_write(CFG_BIAS1, b1);
    cfg_write(CFG_BIAS2, b2);
    cfg_write(CFG_BIAS3, b3);
    cfg_write(CFG_LEARN_RATE, lr);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int       sent;
    int       pick;
    int       len;
    int       len2;
    in_item_t it;
    logic [WGT_W-1:0] w;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Load the live pixel positions of every neuron: neuron 0 at the top, neuron 1 at the bottom.
    for (int n = 0; n < NUM_NEURONS; n++) begin
      for (int j = 0; j < LIVE_PIXELS; j++) begin
        if (n == 0) w = WGT_TOP;
        else if (n == 1) w = WGT_BOTTOM;
        else w = pick_weight();
        send_item(load_item(WADDR_W'(n * NUM_INPUTS + j), w));
      end
    end

    // A full image defines every pixel; two extra pixels and a dropped last pixel follow.
    feed_pixels(NUM_INPUTS + 2, 100, 1'b0);
    send_item(pixel_item(1'b1, 1'b1));

    // Loads past the store and an unused opcode are ignored.
    send_item(load_item(9'(WCOUNT), WGT_TOP));
    send_item(load_item(9'h1FF, WGT_BOTTOM));
    send_item(idle_op_item());

    // Training with all targets clear and all set, then single-pixel images.
    send_item(train_item(4'b0000));
    send_item(train_item(4'b1111));
    feed_pixels(1, 100, 1'b1);
    feed_pixels(1, 0, 1'b1);

    // Top of every register range.
    settle();
    program_layer(WGT_TOP, WGT_TOP, WGT_TOP, WGT_TOP, LR_TOP, 1'b1);
    feed_pixels(3, 100, 1'b1);
    send_item(train_item(4'b0101));

    // Bottom of every register range.
    settle();
    program_layer(WGT_BOTTOM, WGT_BOTTOM, WGT_BOTTOM, WGT_BOTTOM, '0, 1'b0);
    feed_pixels(2, 50, 1'b1);
    send_item(train_item(4'b1010));
    feed_pixels(1, 100, 1'b1);

    // Random phases, each under its own register setting.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      if (p == 3) begin
        program_layer('0, '0, '0, '0, LR_RESET, 1'b0);
      end else begin
        program_layer(pick_weight(), pick_weight(), pick_weight(), pick_weight(),
                      pick_rate(), 1'b0);
      end
      quiet <= (p == 2);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 58) begin
          // Mostly short images, now and then a long one that may run past the input count.
          len = ($urandom_range(0, 99) < 3) ? $urandom_range(95, 104) : $urandom_range(1, 6);
          feed_pixels(len, $urandom_range(0, 100), 1'b1);
          sent += len;
        end else if (pick < 73) begin
          send_item(train_item(4'($urandom_range(0, 15))));
          sent++;
        end else if (pick < 88) begin
          send_item(load_item(9'($urandom_range(0, WCOUNT - 1)), pick_weight()));
          sent++;
        end else if (pick < 94) begin
          // An image interrupted by a train or a load before its last pixel.
          len  = $urandom_range(1, 4);
          len2 = $urandom_range(1, 3);
          feed_pixels(len, $urandom_range(0, 100), 1'b0);
          if ($urandom_range(0, 1) != 0) begin
            send_item(train_item(4'($urandom_range(0, 15))));
          end else begin
            send_item(load_item(9'($urandom_range(0, WCOUNT - 1)), pick_weight()));
          end
          feed_pixels(len2, $urandom_range(0, 100), 1'b1);
          sent += len + len2 + 1;
        end else begin
          // Ignored transactions: unused opcode or a load past the store.
          if ($urandom_range(0, 1) != 0) it = idle_op_item();
          else it = load_item(9'($urandom_range(WCOUNT, 511)), pick_weight());
          send_item(it);
          sent++;
        end
      end
    end

    // Drain and decide.
    settle();
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("dense_relu_layer_with_delta_update regression: pass");
    end else begin
      $display("dense_relu_layer_with_delta_update regression: fail");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/drlu_pkg.sv
hdl/drlu_ram.sv
hdl/drlu_front.sv
hdl/drlu_fifo.sv
hdl/drlu_back.sv
hdl/dense_relu_layer_with_delta_update.sv
sim/drlu_activation_checker.sv
sim/dense_relu_layer_with_delta_update_tb.sv
